### rtl/bwt_pkg.sv
// Shared codes, constants and symbol packing helpers for the BWT builder.
package bwt_pkg;

  localparam int CODE_BITS = 3;
  localparam int BYTE_W = 8;
  localparam int WIN_TOP = 2 * BYTE_W - CODE_BITS;
  localparam int LEN_W = 21;
  localparam logic [LEN_W-1:0] GENOME_LEN_RESET = 21'd1048576;
  localparam logic [CODE_BITS-1:0] FIRST_BAD_CODE = 3'd5;

  // word address of the only register, taken from paddr[2]
  localparam logic REG_GENOME_LENGTH = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_XFORM = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_CODE  = 2'd2,
    ST_ADDR  = 2'd3
  } status_t;

  // pull one code out of a two-byte window, MSB first
  function automatic logic [CODE_BITS-1:0] extract_code(
    input logic [BYTE_W-1:0] hi,
    input logic [BYTE_W-1:0] lo,
    input logic [2:0] off
  );
    logic [2*BYTE_W-1:0] win;
    logic [2*BYTE_W-1:0] sh;
    begin
      win = {hi, lo};
      sh = win >> (4'(WIN_TOP) - {1'b0, off});
      extract_code = sh[CODE_BITS-1:0];
    end
  endfunction

  // place a code into a two-byte window at the given bit offset
  function automatic logic [2*BYTE_W-1:0] place_code(
    input logic [CODE_BITS-1:0] code,
    input logic [2:0] off
  );
    begin
      place_code = (2*BYTE_W)'(code) << (4'(WIN_TOP) - {1'b0, off});
    end
  endfunction

endpackage

### rtl/bwt_xform_mem.sv
// Transform byte store: two read ports, one write port, zeroing sweep after reset.
module bwt_xform_mem #(
  parameter int DEPTH = 393217,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [AW-1:0]             raddr0,
  input  logic [AW-1:0]             raddr1,
  output logic [bwt_pkg::BYTE_W-1:0] rdata0,
  output logic [bwt_pkg::BYTE_W-1:0] rdata1,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [bwt_pkg::BYTE_W-1:0] wdata,
  output logic                      clearing
);

  logic [bwt_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [AW-1:0]              clr_addr;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [bwt_pkg::BYTE_W-1:0] mem_wdata;

  always_comb begin
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = we;
      mem_waddr = waddr;
      mem_wdata = wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

`ifndef NO_ASSERTIONS
  // the sweep must not outlive the store
  a_clr_bound: assert property (@(posedge clk) disable iff (rst)
    clearing |-> clr_addr <= AW'(DEPTH - 1))
    else $error("clear address past end of store");

  a_clr_end: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> $past(clr_addr) == AW'(DEPTH - 1))
    else $error("clear pass ended early");

  a_clr_step: assert property (@(posedge clk) disable iff (rst)
    (clearing && $past(clearing) && !$past(rst)) |-> clr_addr == $past(clr_addr) + AW'(1))
    else $error("clear pass skipped an entry");
`endif

endmodule

### rtl/bwt_from_suffix_array_3bit.sv
// Top level: builds a packed 3-bit BWT from suffix array entries.
//
//  channel   direction  handshake              payload
//  request   in         start high, busy low   cmd byte_addr byte_data row_index suffix_pos
//  result    out        done for one cycle     symbol_code read_byte status
//  config    in         APB write, pready = 1  genome_length at word 0
//
// Genome load, out-of-range suffix entry and bad requests finish in S_RD; an output read and
// a suffix entry with an invalid code finish in S_MOD; other suffix entries also pass S_WR2.
// S_RD reads two genome bytes and two transform bytes, S_MOD merges the code and writes
// the first byte, S_WR2 writes the second byte on the single transform write port.
// Reset is synchronous; afterwards the transform store is zeroed one byte a cycle, all
// MAX_SYMBOLS*3/8+1 bytes (393217 at the default), with busy held high.
// The result is shown for one cycle and cannot be held off.
module bwt_from_suffix_array_3bit #(
  parameter int MAX_SYMBOLS = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [18:0] byte_addr,
  input  logic [7:0]  byte_data,
  input  logic [19:0] row_index,
  input  logic [19:0] suffix_pos,
  output logic        done,
  output logic [2:0]  symbol_code,
  output logic [7:0]  read_byte,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int STORE_BYTES = MAX_SYMBOLS * bwt_pkg::CODE_BITS / 8 + 1;
  localparam int AW = $clog2(STORE_BYTES);
  localparam int LW = $clog2(MAX_SYMBOLS + 1);
  localparam int PW = $clog2(MAX_SYMBOLS);
  localparam int BW = PW + 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_WR2
  } state_t;

  state_t                          state;
  bwt_pkg::cmd_t                   cmd_q;
  logic [18:0]                     addr_q;
  logic [7:0]                      data_q;
  logic [PW-1:0]                   row_q;
  logic [PW-1:0]                   prev_q;
  logic                            range_bad_q;
  logic [7:0]                      lo_q;
  logic [bwt_pkg::CODE_BITS-1:0]   code_q;
  logic [bwt_pkg::LEN_W-1:0]       genome_length;

  logic [LW-1:0]                   eff_len;
  logic                            range_bad;
  logic [PW-1:0]                   prev_next;
  logic                            accept;
  logic                            addr_ok;
  logic [BW-1:0]                   g_bit;
  logic [BW-1:0]                   r_bit;
  logic [AW-1:0]                   g_b;
  logic [AW-1:0]                   g_b1;
  logic [AW-1:0]                   r_b;
  logic [AW-1:0]                   r_b1;
  logic [bwt_pkg::CODE_BITS-1:0]   code;
  logic [15:0]                     mask;

  logic [7:0]                      genome_mem [STORE_BYTES];
  logic [7:0]                      g_rd0;
  logic [7:0]                      g_rd1;
  logic                            g_we;

  logic [AW-1:0]                   t_raddr0;
  logic [7:0]                      t_rd0;
  logic [7:0]                      t_rd1;
  logic                            t_we;
  logic [AW-1:0]                   t_waddr;
  logic [7:0]                      t_wdata;
  logic                            clearing;

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bwt_pkg::REG_GENOME_LENGTH) ?
                  32'(genome_length) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      genome_length <= bwt_pkg::GENOME_LEN_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == bwt_pkg::REG_GENOME_LENGTH) begin
      genome_length <= pwdata[bwt_pkg::LEN_W-1:0];
    end
  end

  // clamp length, check range and pick the symbol before the suffix
  always_comb begin
    eff_len = (32'(genome_length) > 32'(MAX_SYMBOLS)) ? LW'(MAX_SYMBOLS) :
              LW'(genome_length);
    range_bad = (32'(suffix_pos) >= 32'(eff_len)) || (32'(row_index) >= 32'(eff_len));
    prev_next = (suffix_pos == 20'd0) ? PW'(eff_len - LW'(1)) :
                PW'(suffix_pos - 20'd1);
  end

  assign busy    = (state != S_IDLE) || clearing;
  assign accept  = start && !busy;
  assign addr_ok = 32'(addr_q) < 32'(STORE_BYTES);

  // bit position is three times the symbol index
  always_comb begin
    g_bit = (BW'(prev_q) << 1) + BW'(prev_q);
    r_bit = (BW'(row_q) << 1) + BW'(row_q);
    g_b   = AW'(g_bit >> 3);
    g_b1  = g_b + AW'(1);
    r_b   = AW'(r_bit >> 3);
    r_b1  = r_b + AW'(1);
    code  = bwt_pkg::extract_code(g_rd0, g_rd1, g_bit[2:0]);
    mask  = bwt_pkg::place_code(code, r_bit[2:0]);
  end

  assign g_we     = (state == S_RD) && (cmd_q == bwt_pkg::CMD_LOAD) && addr_ok;
  assign t_raddr0 = (cmd_q == bwt_pkg::CMD_READ) ? AW'(addr_q) : r_b;

  always_comb begin
    t_we    = 1'b0;
    t_waddr = r_b;
    t_wdata = t_rd0 | mask[15:8];
    unique case (state)
      S_MOD: begin
        t_we = (cmd_q == bwt_pkg::CMD_XFORM) && (code < bwt_pkg::FIRST_BAD_CODE);
      end
      S_WR2: begin
        t_we    = 1'b1;
        t_waddr = r_b1;
        t_wdata = lo_q;
      end
      S_IDLE, S_RD: begin
        t_we = 1'b0;
      end
      default: begin
        t_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      genome_mem[AW'(addr_q)] <= data_q;
    end
    g_rd0 <= genome_mem[g_b];
    g_rd1 <= genome_mem[g_b1];
  end

  bwt_xform_mem #(
    .DEPTH (STORE_BYTES)
  ) u_xform_mem (
    .clk      (clk),
    .rst      (rst),
    .raddr0   (t_raddr0),
    .raddr1   (r_b1),
    .rdata0   (t_rd0),
    .rdata1   (t_rd1),
    .we       (t_we),
    .waddr    (t_waddr),
    .wdata    (t_wdata),
    .clearing (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (accept) begin
            cmd_q       <= bwt_pkg::cmd_t'(cmd);
            addr_q      <= byte_addr;
            data_q      <= byte_data;
            row_q       <= PW'(row_index);
            prev_q      <= prev_next;
            range_bad_q <= range_bad;
            state       <= S_RD;
          end
        end
        S_RD: begin
          symbol_code <= '0;
          read_byte   <= '0;
          unique case (cmd_q)
            bwt_pkg::CMD_LOAD: begin
              done   <= 1'b1;
              status <= addr_ok ? bwt_pkg::ST_OK : bwt_pkg::ST_ADDR;
              state  <= S_IDLE;
            end
            bwt_pkg::CMD_XFORM: begin
              if (range_bad_q) begin
                done   <= 1'b1;
                status <= bwt_pkg::ST_RANGE;
                state  <= S_IDLE;
              end else begin
                done  <= 1'b0;
                state <= S_MOD;
              end
            end
            bwt_pkg::CMD_READ: begin
              if (addr_ok) begin
                done  <= 1'b0;
                state <= S_MOD;
              end else begin
                done   <= 1'b1;
                status <= bwt_pkg::ST_ADDR;
                state  <= S_IDLE;
              end
            end
            bwt_pkg::CMD_NONE: begin
              done   <= 1'b1;
              status <= bwt_pkg::ST_ADDR;
              state  <= S_IDLE;
            end
            default: begin
              done  <= 1'b0;
              state <= S_IDLE;
            end
          endcase
        end
        S_MOD: begin
          if (cmd_q == bwt_pkg::CMD_READ) begin
            done        <= 1'b1;
            symbol_code <= '0;
            read_byte   <= t_rd0;
            status      <= bwt_pkg::ST_OK;
            state       <= S_IDLE;
          end else if (code >= bwt_pkg::FIRST_BAD_CODE) begin
            done        <= 1'b1;
            symbol_code <= code;
            read_byte   <= '0;
            status      <= bwt_pkg::ST_CODE;
            state       <= S_IDLE;
          end else begin
            // hold the low byte for the second write
            done   <= 1'b0;
            lo_q   <= t_rd1 | mask[7:0];
            code_q <= code;
            state  <= S_WR2;
          end
        end
        S_WR2: begin
          done        <= 1'b1;
          symbol_code <= code_q;
          read_byte   <= '0;
          status      <= bwt_pkg::ST_OK;
          state       <= S_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != S_IDLE))
    else $error("result without a request in flight");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == bwt_pkg::ST_RANGE) |-> (symbol_code == '0 && read_byte == '0))
    else $error("range error result carries data");

  a_bad_code: assert property (@(posedge clk) disable iff (rst)
    (done && status == bwt_pkg::ST_CODE) |-> symbol_code >= bwt_pkg::FIRST_BAD_CODE)
    else $error("invalid code status with a valid code");

  a_no_work_clear: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !clearing)
    else $error("request in flight during clear pass");
`endif

endmodule

### test/tb_bwt_from_suffix_array_3bit.sv
// Testbench for the 3-bit BWT builder: genome loads, suffix entries and output reads checked.
`timescale 1ns / 100ps

module tb_bwt_from_suffix_array_3bit;

  localparam int MAX_SYMBOLS = 1048576;
  localparam int STORE_BYTES = MAX_SYMBOLS * bwt_pkg::CODE_BITS / 8 + 1;
  localparam int SEG_ITEMS = 60;

  typedef struct packed {
    bwt_pkg::cmd_t cmd;
    logic [18:0]   byte_addr;
    logic [7:0]    byte_data;
    logic [19:0]   row_index;
    logic [19:0]   suffix_pos;
  } bwt_req_t;

  typedef struct packed {
    logic [2:0]       symbol_code;
    logic [7:0]       read_byte;
    bwt_pkg::status_t status;
  } bwt_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  cmd;
  logic [18:0] byte_addr;
  logic [7:0]  byte_data;
  logic [19:0] row_index;
  logic [19:0] suffix_pos;
  logic        done;
  logic [2:0]  symbol_code;
  logic [7:0]  read_byte;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bwt_req_t   drv_req = '0;
  bwt_req_t   cmd_queue [$];
  bwt_reply_t expected_replies [$];
  logic       req_taken = 1'b0;
  int         sender_idle_pct = 26;
  int         issued_count = 0;
  int         answered_count = 0;
  int         mismatch_count = 0;

  // predictor state
  logic [7:0]  genome_img [int];
  logic [7:0]  xform_img [int];
  logic [20:0] len_reg = bwt_pkg::GENOME_LEN_RESET;

  // generator view: which genome bytes hold data, and the clamped length in force
  bit genome_loaded [int];
  int gen_len = MAX_SYMBOLS;

  int n_loads = 0, n_xforms = 0, n_reads = 0, n_range = 0, n_bad_code = 0;
  int n_bad_addr = 0, n_settings = 0;

  assign cmd        = drv_req.cmd;
  assign byte_addr  = drv_req.byte_addr;
  assign byte_data  = drv_req.byte_data;
  assign row_index  = drv_req.row_index;
  assign suffix_pos = drv_req.suffix_pos;

  bwt_from_suffix_array_3bit #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .byte_addr(byte_addr),
    .byte_data(byte_data),
    .row_index(row_index),
    .suffix_pos(suffix_pos),
    .done(done),
    .symbol_code(symbol_code),
    .read_byte(read_byte),
    .status(status),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // work out the reply to one accepted request and update the stores
  function automatic bwt_reply_t step_bwt(bwt_req_t rq);
    bwt_reply_t rp;
    int eff, prev, bitpos, b;
    logic [2:0] off;
    logic [7:0] hi, lo;
    logic [15:0] win;
    rp = '{symbol_code: 3'd0, read_byte: 8'd0, status: bwt_pkg::ST_OK};
    eff = (len_reg > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(len_reg);
    case (rq.cmd)
      bwt_pkg::CMD_LOAD: begin
        n_loads++;
        if (rq.byte_addr < STORE_BYTES) begin
          genome_img[int'(rq.byte_addr)] = rq.byte_data;
        end else begin
          rp.status = bwt_pkg::ST_ADDR;
          n_bad_addr++;
        end
      end
      bwt_pkg::CMD_XFORM: begin
        n_xforms++;
        if (eff == 0 || rq.suffix_pos >= eff || rq.row_index >= eff) begin
          rp.status = bwt_pkg::ST_RANGE;
          n_range++;
        end else begin
          // suffix 0 wraps to the last symbol
          prev = (rq.suffix_pos == 0) ? eff - 1 : int'(rq.suffix_pos) - 1;
          bitpos = prev * bwt_pkg::CODE_BITS;
          b = bitpos >> 3;
          off = bitpos[2:0];
          hi = genome_img.exists(b) ? genome_img[b] : 8'h00;
          lo = genome_img.exists(b + 1) ? genome_img[b + 1] : 8'h00;
          win = {hi, lo} >> (bwt_pkg::WIN_TOP - off);
          rp.symbol_code = win[2:0];
          if (rp.symbol_code >= bwt_pkg::FIRST_BAD_CODE) begin
            rp.status = bwt_pkg::ST_CODE;
            n_bad_code++;
          end else begin
            bitpos = int'(rq.row_index) * bwt_pkg::CODE_BITS;
            b = bitpos >> 3;
            off = bitpos[2:0];
            win = 16'(rp.symbol_code) << (bwt_pkg::WIN_TOP - off);
            if (!xform_img.exists(b)) xform_img[b] = 8'h00;
            if (!xform_img.exists(b + 1)) xform_img[b + 1] = 8'h00;
            xform_img[b] = xform_img[b] | win[15:8];
            xform_img[b + 1] = xform_img[b + 1] | win[7:0];
          end
        end
      end
      bwt_pkg::CMD_READ: begin
        n_reads++;
        if (rq.byte_addr < STORE_BYTES) begin
          if (xform_img.exists(int'(rq.byte_addr))) rp.read_byte = xform_img[int'(rq.byte_addr)];
        end else begin
          rp.status = bwt_pkg::ST_ADDR;
          n_bad_addr++;
        end
      end
      default: begin
        rp.status = bwt_pkg::ST_ADDR;
        n_bad_addr++;
      end
    endcase
    return rp;
  endfunction

  // queue one request; a suffix entry first gets loads for any genome byte it reads
  task automatic push_req(input bwt_pkg::cmd_t c, input logic [18:0] a, input logic [7:0] d,
                          input logic [19:0] row, input logic [19:0] suf);
    bwt_req_t rq;
    int prev, b;
    if (c == bwt_pkg::CMD_XFORM && (suf != 0 || gen_len != 0)) begin
      prev = (suf == 0) ? gen_len - 1 : int'(suf) - 1;
      b = prev * bwt_pkg::CODE_BITS / 8;
      for (int k = 0; k < 2; k++) begin
        if (!genome_loaded.exists(b + k))
          push_req(bwt_pkg::CMD_LOAD, 19'(b + k), 8'($urandom), 20'($urandom),
                   20'($urandom));
      end
    end
    if (c == bwt_pkg::CMD_LOAD && a < STORE_BYTES) genome_loaded[int'(a)] = 1'b1;
    rq = '{cmd: c, byte_addr: a, byte_data: d, row_index: row, suffix_pos: suf};
    cmd_queue.push_back(rq);
    issued_count++;
  endtask

  // position mostly near the start or the end of the genome, sometimes anywhere
  function automatic int pick_pos(int len);
    int r, span;
    if (len == 0) return int'($urandom_range(0, 20'hFFFFF));
    span = (len < 48) ? len : 48;
    r = $urandom_range(0, 99);
    if (r < 65) return int'($urandom_range(0, span - 1));
    if (r < 80) return len - 1 - int'($urandom_range(0, (len < 8 ? len : 8) - 1));
    if (r < 92) return int'($urandom_range(0, len - 1));
    return int'($urandom_range(0, 20'hFFFFF));
  endfunction

  task automatic gen_random_items(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        if ($urandom_range(0, 6) == 0)
          push_req(bwt_pkg::CMD_LOAD, 19'($urandom), 8'($urandom), 20'($urandom),
                   20'($urandom));
        else
          push_req(bwt_pkg::CMD_LOAD,
                   19'(pick_pos(gen_len) * bwt_pkg::CODE_BITS / 8 + $urandom_range(0, 1)),
                   8'($urandom), 20'($urandom), 20'($urandom));
      end else if (r < 67) begin
        push_req(bwt_pkg::CMD_XFORM, 19'($urandom), 8'($urandom), 20'(pick_pos(gen_len)),
                 20'(pick_pos(gen_len)));
      end else if (r < 95) begin
        if ($urandom_range(0, 7) == 0)
          push_req(bwt_pkg::CMD_READ, 19'($urandom), 8'($urandom), 20'($urandom),
                   20'($urandom));
        else
          push_req(bwt_pkg::CMD_READ,
                   19'(pick_pos(gen_len) * bwt_pkg::CODE_BITS / 8 + $urandom_range(0, 1)),
                   8'($urandom), 20'($urandom), 20'($urandom));
      end else begin
        push_req(bwt_pkg::CMD_NONE, 19'($urandom), 8'($urandom), 20'($urandom),
                 20'($urandom));
      end
    end
  endtask

  // hold until every issued request has its reply, then let the pipeline settle
  task automatic wait_quiet();
    do @(negedge clk); while (answered_count < issued_count);
    repeat (8) @(negedge clk);
  endtask

  // APB write of the length register, then read it back
  task automatic write_genome_length(input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {bwt_pkg::REG_GENOME_LENGTH, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    len_reg = value[20:0];
    gen_len = (value[20:0] > MAX_SYMBOLS) ? MAX_SYMBOLS : int'(value[20:0]);
    n_settings++;
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[20:0] !== value[20:0]) begin
      mismatch_count++;
      $display("%0t: genome_length readback expected %0d actual %0d", $time, value[20:0],
               prdata[20:0]);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // driver: present the next request once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (cmd_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        drv_req <= cmd_queue.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, compare each reply with the oldest prediction
  always @(posedge clk) begin : reply_check
    bwt_reply_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= start && !busy;
      if (start && !busy) expected_replies.push_back(step_bwt(drv_req));
      if (done) begin
        answered_count++;
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected reply: expected none, actual code %0d byte %02h status %0d",
                   $time, symbol_code, read_byte, status);
        end else begin
          want = expected_replies.pop_front();
          if (symbol_code !== want.symbol_code) begin
            mismatch_count++;
            $display("%0t: symbol_code expected %0d actual %0d", $time, want.symbol_code,
                     symbol_code);
          end
          if (read_byte !== want.read_byte) begin
            mismatch_count++;
            $display("%0t: read_byte expected %02h actual %02h", $time, want.read_byte,
                     read_byte);
          end
          if (status !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          end
        end
      end
    end
  end

  initial begin
    logic [31:0] seg_lengths [9];
    logic [31:0] v;
    seg_lengths = '{32'd45, 32'd1048576, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd300,
                    32'd1048575, 32'd17, 32'd0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // hold off until the transform store clear finishes
    do @(negedge clk); while (busy !== 1'b0);

    // directed: straddling codes, two invalid codes, wrap, repeated row, store edges
    push_req(bwt_pkg::CMD_LOAD, 19'd0, 8'b0000_0101, 20'hFFFFF, 20'h00000);
    push_req(bwt_pkg::CMD_LOAD, 19'd1, 8'b0011_1001, 20'h00000, 20'hFFFFF);
    push_req(bwt_pkg::CMD_LOAD, 19'd2, 8'b1110_1000, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_LOAD, 19'd393215, 8'h5A, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_LOAD, 19'd393216, 8'hC3, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_LOAD, 19'd393217, 8'hFF, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_LOAD, 19'h7FFFF, 8'hFF, 20'hFFFFF, 20'hFFFFF);
    for (int k = 0; k < 7; k++)
      push_req(bwt_pkg::CMD_XFORM, 19'h7FFFF, 8'hFF, 20'(k), 20'(k + 1));
    push_req(bwt_pkg::CMD_XFORM, 19'd0, 8'h00, 20'd0, 20'd4);
    push_req(bwt_pkg::CMD_XFORM, 19'd0, 8'h00, 20'hFFFFF, 20'd0);
    push_req(bwt_pkg::CMD_XFORM, 19'd0, 8'h00, 20'd7, 20'hFFFFF);
    push_req(bwt_pkg::CMD_READ, 19'd0, 8'hFF, 20'hFFFFF, 20'hFFFFF);
    push_req(bwt_pkg::CMD_READ, 19'd1, 8'h00, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_READ, 19'd393215, 8'h00, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_READ, 19'd393216, 8'h00, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_READ, 19'd393217, 8'h00, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_READ, 19'h7FFFF, 8'h00, 20'h00000, 20'h00000);
    push_req(bwt_pkg::CMD_NONE, 19'h7FFFF, 8'hFF, 20'hFFFFF, 20'hFFFFF);
    wait_quiet();

    // random segments, one length setting each; sender idles 26%, then 55%, then never
    for (int seg = 0; seg < 9; seg++) begin
      v = (seg == 8) ? 32'($urandom_range(2, MAX_SYMBOLS)) : seg_lengths[seg];
      write_genome_length(v);
      sender_idle_pct = (seg < 3) ? 26 : (seg < 6) ? 55 : 0;
      gen_random_items(SEG_ITEMS);
      wait_quiet();
    end

    repeat (10) @(negedge clk);
    $display("Covered %0d genome loads, %0d suffix entries (%0d out of range, %0d invalid codes)",
             n_loads, n_xforms, n_range, n_bad_code);
    $display("and %0d output reads; %0d bad addresses or commands; %0d length settings",
             n_reads, n_bad_addr, n_settings);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
